@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top level of the rgb/ypbpr converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// consequence holds in the cycle after
`define ASSERT_IMPLY_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)
`define ASSERT_IMPLY_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

@@ rtl/core/rgbyc_pkg.sv @@
// types, widths and coefficients of the rgb/ypbpr converter
`timescale 1ns / 1ps
`default_nettype none

package rgbyc_pkg;

   // fixed point formats: luma q1.15, colour differences q0.15, coefficients q1.16
   localparam int FRAC_BITS = 15;
   localparam int COEF_BITS = 16;

   localparam int SAMPLE_W = 16;
   localparam int MAXV_W   = 16;
   localparam int OP_W     = SAMPLE_W + 1;
   localparam int COEF_W   = COEF_BITS + 2;
   localparam int PROD_W   = OP_W + COEF_W;
   localparam int SUM_W    = PROD_W + 2;

   // forward magnitude stays below 2^32, numerator adds the rounding term
   localparam int MAG_W    = 2 * SAMPLE_W;
   localparam int NUM_W    = MAG_W + 1;
   localparam int DEN_W    = MAXV_W + 1;
   localparam int QUO_W    = NUM_W - DEN_W;

   // inverse scaling
   localparam int INV_SHIFT = FRAC_BITS + COEF_BITS;
   localparam int INV_T_W   = INV_SHIFT;
   localparam int SCALE_W   = INV_T_W + MAXV_W;

   localparam int FRONT_STAGES = 4;
   localparam int DIV_STAGES   = QUO_W;
   localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

   localparam logic [SAMPLE_W-1:0] LUMA_ONE  = SAMPLE_W'(1 << FRAC_BITS);
   localparam logic [SAMPLE_W-1:0] DIFF_HALF = SAMPLE_W'(1 << (FRAC_BITS - 1));

   localparam logic [MAXV_W-1:0] MAXVAL_RESET = MAXV_W'(255);

   localparam logic CMD_FORWARD = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_MAXVAL  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAXVAL = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic [SAMPLE_W-1:0] luma;
      logic [SAMPLE_W-1:0] blue_diff;
      logic [SAMPLE_W-1:0] red_diff;
   } pix_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] fwd_r;
      logic signed [COEF_W-1:0] fwd_g;
      logic signed [COEF_W-1:0] fwd_b;
      logic signed [COEF_W-1:0] inv_y;
      logic signed [COEF_W-1:0] inv_pb;
      logic signed [COEF_W-1:0] inv_pr;
   } lane_coef_type;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] load;
   } pipe_ctl_type;

   typedef struct packed {
      logic                cmd;
      logic                neg;
      logic                ovf;
      logic [QUO_W-1:0]    quo;
      logic [SAMPLE_W-1:0] rgb;
   } lane_res_type;

   // lane 0: y / red, lane 1: pb / green, lane 2: pr / blue
   localparam lane_coef_type COEF_LANE_Y = '{
      fwd_r:  18'sd19595,  fwd_g:  18'sd38470,  fwd_b:  18'sd7471,
      inv_y:  18'sd65536,  inv_pb: 18'sd0,      inv_pr: 18'sd91881};
   localparam lane_coef_type COEF_LANE_PB = '{
      fwd_r: -18'sd11058,  fwd_g: -18'sd21710,  fwd_b:  18'sd32768,
      inv_y:  18'sd65536,  inv_pb: -18'sd22553, inv_pr: -18'sd46802};
   localparam lane_coef_type COEF_LANE_PR = '{
      fwd_r:  18'sd32768,  fwd_g: -18'sd27439,  fwd_b: -18'sd5329,
      inv_y:  18'sd65536,  inv_pb: 18'sd116130, inv_pr: 18'sd0};

endpackage

`default_nettype wire

@@ rtl/core/rgbyc_lane.sv @@
// one colour component lane: dot product, pipelined divider and inverse scaling
`timescale 1ns / 1ps
`default_nettype none

module rgbyc_lane (
   input  logic                                 clock,
   input  rgbyc_pkg::pipe_ctl_type              ctl,
   input  rgbyc_pkg::pix_type                   pix,
   input  rgbyc_pkg::lane_coef_type             coef,
   input  logic [rgbyc_pkg::MAXV_W-1:0]         in_max,
   input  logic [rgbyc_pkg::MAXV_W-1:0]         out_max,
   output rgbyc_pkg::lane_res_type              res
);
   import rgbyc_pkg::*;

   typedef struct packed {
      logic                     cmd;
      logic signed [PROD_W-1:0] pa;
      logic signed [PROD_W-1:0] pb;
      logic signed [PROD_W-1:0] pc;
   } s1_type;

   typedef struct packed {
      logic                    cmd;
      logic signed [SUM_W-1:0] t;
   } s2_type;

   typedef struct packed {
      logic               cmd;
      logic               neg;
      logic [MAG_W-1:0]   mag;
      logic               inv_zero;
      logic               inv_full;
      logic [INV_T_W-1:0] tpos;
   } s3_type;

   typedef struct packed {
      logic               cmd;
      logic               neg;
      logic [NUM_W-1:0]   num;
      logic               ovf;
      logic               inv_zero;
      logic               inv_full;
      logic [SCALE_W-1:0] prod;
   } s4_type;

   typedef struct packed {
      logic                cmd;
      logic                neg;
      logic                ovf;
      logic [NUM_W-1:0]    rem;
      logic [QUO_W-1:0]    quo;
      logic [SAMPLE_W-1:0] rgb;
   } div_type;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   div_type div_head;
   div_type div_ff [DIV_STAGES];

   logic signed [OP_W-1:0]   op_a, op_b, op_c;
   logic signed [COEF_W-1:0] k_a, k_b, k_c;
   logic [SUM_W-1:0]         abs_t;
   logic [DEN_W-1:0]         den;
   logic [SCALE_W-1:0]       rnd;

   assign den = {in_max, 1'b0};

   // stage 1: operand pick and three products
   always_comb begin
      if (pix.cmd == CMD_INVERSE) begin
         op_a = $signed({1'b0, pix.luma});
         op_b = $signed({pix.blue_diff[SAMPLE_W-1], pix.blue_diff});
         op_c = $signed({pix.red_diff[SAMPLE_W-1], pix.red_diff});
         k_a  = $signed(coef.inv_y);
         k_b  = $signed(coef.inv_pb);
         k_c  = $signed(coef.inv_pr);
      end else begin
         op_a = $signed({1'b0, pix.red});
         op_b = $signed({1'b0, pix.green});
         op_c = $signed({1'b0, pix.blue});
         k_a  = $signed(coef.fwd_r);
         k_b  = $signed(coef.fwd_g);
         k_c  = $signed(coef.fwd_b);
      end
      s1_in.cmd = pix.cmd;
      s1_in.pa  = op_a * k_a;
      s1_in.pb  = op_b * k_b;
      s1_in.pc  = op_c * k_c;
   end

   // stage 2: sum
   always_comb begin
      s2_in.cmd = s1_ff.cmd;
      s2_in.t   = SUM_W'($signed(s1_ff.pa)) + SUM_W'($signed(s1_ff.pb))
                + SUM_W'($signed(s1_ff.pc));
   end

   // stage 3: sign and magnitude, inverse range flags
   always_comb begin
      abs_t          = s2_ff.t[SUM_W-1] ? SUM_W'(-s2_ff.t) : s2_ff.t;
      s3_in.cmd      = s2_ff.cmd;
      s3_in.neg      = s2_ff.t[SUM_W-1];
      s3_in.mag      = abs_t[MAG_W-1:0];
      s3_in.inv_zero = s2_ff.t[SUM_W-1] || (s2_ff.t == '0);
      s3_in.inv_full = !s2_ff.t[SUM_W-1] && (s2_ff.t[SUM_W-2:INV_T_W] != '0);
      s3_in.tpos     = s2_ff.t[INV_T_W-1:0];
   end

   // stage 4: q = (mag + max) / (2 max) gives round half away from zero
   always_comb begin
      s4_in.cmd      = s3_ff.cmd;
      s4_in.neg      = s3_ff.neg;
      s4_in.num      = {1'b0, s3_ff.mag} + NUM_W'(in_max);
      s4_in.ovf      = s4_in.num >= {den, {QUO_W{1'b0}}};
      s4_in.inv_zero = s3_ff.inv_zero;
      s4_in.inv_full = s3_ff.inv_full;
      s4_in.prod     = s3_ff.tpos * out_max;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) s1_ff <= s1_in;
      if (ctl.load[1]) s2_ff <= s2_in;
      if (ctl.load[2]) s3_ff <= s3_in;
      if (ctl.load[3]) s4_ff <= s4_in;
   end

   // inverse result settles here and rides along the divider
   always_comb begin
      rnd          = s4_ff.prod + (SCALE_W'(1) << (INV_SHIFT - 1));
      div_head.cmd = s4_ff.cmd;
      div_head.neg = s4_ff.neg;
      div_head.ovf = s4_ff.ovf;
      div_head.rem = s4_ff.num;
      div_head.quo = '0;
      if (s4_ff.inv_zero) begin
         div_head.rgb = '0;
      end else if (s4_ff.inv_full) begin
         div_head.rgb = out_max;
      end else begin
         div_head.rgb = rnd[SCALE_W-1:INV_SHIFT];
      end
   end

   // restoring divider, one quotient bit per stage, msb first
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int SH = DIV_STAGES - 1 - j;
      div_type          src;
      div_type          step_in;
      logic [NUM_W-1:0] step_den;

      if (j == 0) begin : g_head
         assign src = div_head;
      end else begin : g_chain
         assign src = div_ff[j-1];
      end

      assign step_den = NUM_W'(den) << SH;

      always_comb begin
         step_in = src;
         if (src.rem >= step_den) begin
            step_in.rem     = src.rem - step_den;
            step_in.quo[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.load[FRONT_STAGES+j]) div_ff[j] <= step_in;
      end
   end

   assign res.cmd = div_ff[DIV_STAGES-1].cmd;
   assign res.neg = div_ff[DIV_STAGES-1].neg;
   assign res.ovf = div_ff[DIV_STAGES-1].ovf;
   assign res.quo = div_ff[DIV_STAGES-1].quo;
   assign res.rgb = div_ff[DIV_STAGES-1].rgb;

endmodule

`default_nettype wire

@@ rtl/core/rgbyc_merge.sv @@
// merge of the three lanes: clamping, sign and output register
`timescale 1ns / 1ps
`default_nettype none

module rgbyc_merge (
   input  logic                                clock,
   input  logic                                load,
   input  rgbyc_pkg::lane_res_type             res_y,
   input  rgbyc_pkg::lane_res_type             res_pb,
   input  rgbyc_pkg::lane_res_type             res_pr,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]      out_luma,
   output logic signed [rgbyc_pkg::SAMPLE_W-1:0] out_blue_diff,
   output logic signed [rgbyc_pkg::SAMPLE_W-1:0] out_red_diff,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]      out_red,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]      out_green,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]      out_blue
);
   import rgbyc_pkg::*;

   logic [SAMPLE_W-1:0] luma_ff, luma_in;
   logic [SAMPLE_W-1:0] pb_ff, pb_in;
   logic [SAMPLE_W-1:0] pr_ff, pr_in;
   logic [SAMPLE_W-1:0] red_ff, red_in;
   logic [SAMPLE_W-1:0] green_ff, green_in;
   logic [SAMPLE_W-1:0] blue_ff, blue_in;

   function automatic logic [SAMPLE_W-1:0] clamp_mag(lane_res_type r,
                                                     logic [SAMPLE_W-1:0] lim);
      return (r.ovf || (r.quo > lim)) ? lim : r.quo;
   endfunction

   function automatic logic [SAMPLE_W-1:0] signed_diff(lane_res_type r);
      logic [SAMPLE_W-1:0] m;
      m = clamp_mag(r, DIFF_HALF);
      return r.neg ? SAMPLE_W'(-m) : m;
   endfunction

   // forward fields are zero for inverse transactions and the other way round
   always_comb begin
      if (res_y.cmd == CMD_INVERSE) begin
         luma_in  = '0;
         pb_in    = '0;
         pr_in    = '0;
         red_in   = res_y.rgb;
         green_in = res_pb.rgb;
         blue_in  = res_pr.rgb;
      end else begin
         luma_in  = clamp_mag(res_y, LUMA_ONE);
         pb_in    = signed_diff(res_pb);
         pr_in    = signed_diff(res_pr);
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         luma_ff  <= luma_in;
         pb_ff    <= pb_in;
         pr_ff    <= pr_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_luma      = luma_ff;
   assign out_blue_diff = $signed(pb_ff);
   assign out_red_diff  = $signed(pr_ff);
   assign out_red       = red_ff;
   assign out_green     = green_ff;
   assign out_blue      = blue_ff;

endmodule

`default_nettype wire

@@ rtl/core/rgb_ypbpr_convert.sv @@
// top level of the bt.601 rgb/ypbpr converter
//
// channel  dir  handshake             payload
// req      in   req_valid/req_stall   command, red, green, blue, luma, blue_diff, red_diff
// rsp      out  rsp_valid/rsp_stall   out_luma, out_blue_diff, out_red_diff, out_red/green/blue
// csr      in   csr_wr_en             csr_index, csr_wdata
//
// one pixel per clock sustained while rsp_stall is low
// most of the pipeline is the 16-stage restoring divider behind the division by input_maxval
// three lanes (y/red, pb/green, pr/blue) run in lock step, the merge stage is the output register
// synchronous reset empties the pipeline and sets both maxval registers to 255
// under rsp_stall the stages behind the output keep filling until no bubble is left
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgb_ypbpr_convert (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_command,
   input  logic [rgbyc_pkg::SAMPLE_W-1:0]          req_red,
   input  logic [rgbyc_pkg::SAMPLE_W-1:0]          req_green,
   input  logic [rgbyc_pkg::SAMPLE_W-1:0]          req_blue,
   input  logic [rgbyc_pkg::SAMPLE_W-1:0]          req_luma,
   input  logic signed [rgbyc_pkg::SAMPLE_W-1:0]   req_blue_diff,
   input  logic signed [rgbyc_pkg::SAMPLE_W-1:0]   req_red_diff,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]          rsp_out_luma,
   output logic signed [rgbyc_pkg::SAMPLE_W-1:0]   rsp_out_blue_diff,
   output logic signed [rgbyc_pkg::SAMPLE_W-1:0]   rsp_out_red_diff,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]          rsp_out_red,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]          rsp_out_green,
   output logic [rgbyc_pkg::SAMPLE_W-1:0]          rsp_out_blue,
   input  logic                                    csr_wr_en,
   input  logic [rgbyc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rgbyc_pkg::MAXV_W-1:0]            csr_wdata
);
   import rgbyc_pkg::*;

   logic [MAXV_W-1:0]      in_maxval_ff;
   logic [MAXV_W-1:0]      out_maxval_ff;
   logic [MAXV_W-1:0]      in_max_eff;
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [PIPE_STAGES-1:0] valid_src;
   logic [PIPE_STAGES:0]   ready;
   logic                   rsp_valid_ff, rsp_valid_in;
   pipe_ctl_type           ctl;
   pix_type                pix;
   lane_res_type           res_y, res_pb, res_pr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_maxval_ff  <= MAXVAL_RESET;
         out_maxval_ff <= MAXVAL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IN_MAXVAL:  in_maxval_ff  <= csr_wdata;
            CSR_OUT_MAXVAL: out_maxval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero divisor behaves as one
   assign in_max_eff = (in_maxval_ff == '0) ? MAXV_W'(1) : in_maxval_ff;

   // a stage may load when it is empty or the one after it moves
   assign ready[PIPE_STAGES] = !rsp_valid_ff || !rsp_stall;
   for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_ready
      assign ready[i] = !valid_ff[i] || ready[i+1];
   end

   assign valid_src    = {valid_ff[PIPE_STAGES-2:0], req_valid};
   assign valid_in     = (ready[PIPE_STAGES-1:0] & valid_src)
                       | (~ready[PIPE_STAGES-1:0] & valid_ff);
   assign rsp_valid_in = ready[PIPE_STAGES] ? valid_ff[PIPE_STAGES-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign ctl.load  = ready[PIPE_STAGES-1:0];
   assign req_stall = !ready[0];
   assign rsp_valid = rsp_valid_ff;

   assign pix.cmd       = req_command;
   assign pix.red       = req_red;
   assign pix.green     = req_green;
   assign pix.blue      = req_blue;
   assign pix.luma      = req_luma;
   assign pix.blue_diff = req_blue_diff;
   assign pix.red_diff  = req_red_diff;

   rgbyc_lane u_lane_y (
      .clock   (clock),
      .ctl     (ctl),
      .pix     (pix),
      .coef    (COEF_LANE_Y),
      .in_max  (in_max_eff),
      .out_max (out_maxval_ff),
      .res     (res_y)
   );

   rgbyc_lane u_lane_pb (
      .clock   (clock),
      .ctl     (ctl),
      .pix     (pix),
      .coef    (COEF_LANE_PB),
      .in_max  (in_max_eff),
      .out_max (out_maxval_ff),
      .res     (res_pb)
   );

   rgbyc_lane u_lane_pr (
      .clock   (clock),
      .ctl     (ctl),
      .pix     (pix),
      .coef    (COEF_LANE_PR),
      .in_max  (in_max_eff),
      .out_max (out_maxval_ff),
      .res     (res_pr)
   );

   rgbyc_merge u_merge (
      .clock         (clock),
      .load          (ready[PIPE_STAGES]),
      .res_y         (res_y),
      .res_pb        (res_pb),
      .res_pr        (res_pr),
      .out_luma      (rsp_out_luma),
      .out_blue_diff (rsp_out_blue_diff),
      .out_red_diff  (rsp_out_red_diff),
      .out_red       (rsp_out_red),
      .out_green     (rsp_out_green),
      .out_blue      (rsp_out_blue)
   );

   // a full pipeline with a held output must push back on the input
   `ASSERT_IMPLY(a_full_stalls, clock, reset, (&valid_ff) && rsp_valid_ff && rsp_stall, req_stall, "full pipeline accepted a transaction")

   // output empties when taken and nothing is behind it
   `ASSERT_IMPLY_NEXT(a_drain, clock, reset, rsp_valid_ff && !rsp_stall && !valid_ff[PIPE_STAGES-1], !rsp_valid_ff, "result repeated after hand-over")

   // only one half of the result carries data
   `ASSERT_IMPLY(a_half_zero, clock, reset, rsp_valid_ff, ((rsp_out_red == '0) && (rsp_out_green == '0) && (rsp_out_blue == '0)) || ((rsp_out_luma == '0) && (rsp_out_blue_diff == '0) && (rsp_out_red_diff == '0)), "both result halves non-zero")

   // clamped ranges of the forward luma and blue_diff fields
   `ASSERT_IMPLY(a_luma_range, clock, reset, rsp_valid_ff, rsp_out_luma <= LUMA_ONE, "luma above one")
   `ASSERT_IMPLY(a_pb_range, clock, reset, rsp_valid_ff, ($signed(rsp_out_blue_diff) >= -16'sd16384) && ($signed(rsp_out_blue_diff) <= 16'sd16384), "pb outside half range")

endmodule

`default_nettype wire

@@ sim/rgb_ypbpr_convert_tb.sv @@
// self-checking testbench for the bt.601 rgb/ypbpr converter with random flow control
`timescale 1ns / 1ps

module rgb_ypbpr_convert_tb;
   import rgbyc_pkg::*;

   localparam int LATENCY     = 20;
   localparam int CYCLE_LIMIT = 200000;

   // bt.601 coefficients in q1.16
   localparam longint K_Y_R  = 19595;
   localparam longint K_Y_G  = 38470;
   localparam longint K_Y_B  = 7471;
   localparam longint K_PB_R = 11058;
   localparam longint K_PB_G = 21710;
   localparam longint K_PB_B = 32768;
   localparam longint K_PR_R = 32768;
   localparam longint K_PR_G = 27439;
   localparam longint K_PR_B = 5329;
   localparam longint K_R_PR = 91881;
   localparam longint K_G_PB = 22553;
   localparam longint K_G_PR = 46802;
   localparam longint K_B_PB = 116130;

   typedef struct packed {
      logic [SAMPLE_W-1:0] luma;
      logic [SAMPLE_W-1:0] blue_diff;
      logic [SAMPLE_W-1:0] red_diff;
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
   } colour_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid     = 1'b0;
   logic                        req_stall;
   logic                        req_command   = CMD_FORWARD;
   logic [SAMPLE_W-1:0]         req_red       = '0;
   logic [SAMPLE_W-1:0]         req_green     = '0;
   logic [SAMPLE_W-1:0]         req_blue      = '0;
   logic [SAMPLE_W-1:0]         req_luma      = '0;
   logic signed [SAMPLE_W-1:0]  req_blue_diff = '0;
   logic signed [SAMPLE_W-1:0]  req_red_diff  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall     = 1'b0;
   logic [SAMPLE_W-1:0]         rsp_out_luma;
   logic signed [SAMPLE_W-1:0]  rsp_out_blue_diff;
   logic signed [SAMPLE_W-1:0]  rsp_out_red_diff;
   logic [SAMPLE_W-1:0]         rsp_out_red;
   logic [SAMPLE_W-1:0]         rsp_out_green;
   logic [SAMPLE_W-1:0]         rsp_out_blue;
   logic                        csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index     = CSR_IN_MAXVAL;
   logic [MAXV_W-1:0]           csr_wdata     = '0;

   // shadow copy of the maxval registers
   logic [MAXV_W-1:0] cfg_in_maxval  = MAXVAL_RESET;
   logic [MAXV_W-1:0] cfg_out_maxval = MAXVAL_RESET;

   pix_type           pending_pixels[$];
   colour_result_type expected_colours[$];

   int  pixels_queued   = 0;
   int  pixels_accepted = 0;
   int  mismatch_count  = 0;
   int  cycle_count     = 0;
   bit  req_taken       = 1'b0;
   int  burst_left      = 0;
   int  gap_left        = 0;
   int  stall_mode      = 0;
   int  stall_phase     = 0;

   rgb_ypbpr_convert uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_luma          (req_luma),
      .req_blue_diff     (req_blue_diff),
      .req_red_diff      (req_red_diff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_luma      (rsp_out_luma),
      .rsp_out_blue_diff (rsp_out_blue_diff),
      .rsp_out_red_diff  (rsp_out_red_diff),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // round(num * 2^15 / den), half away from zero
   function automatic longint scaled_div_round(longint num, longint den);
      bit     neg;
      longint mag;
      longint q;
      neg = num < 0;
      mag = neg ? -num : num;
      q = ((mag << FRAC_BITS) + den / 2) / den;
      return neg ? -q : q;
   endfunction

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // scale a q.31 term by output maxval, round half away from zero, clamp
   function automatic logic [SAMPLE_W-1:0] scale_to_rgb(longint t);
      longint prod;
      longint mag;
      longint q;
      prod = t * longint'(cfg_out_maxval);
      mag = (prod < 0) ? -prod : prod;
      q = (mag + (longint'(1) << (INV_SHIFT - 1))) >> INV_SHIFT;
      if (prod < 0)
         q = -q;
      return SAMPLE_W'(clamp_range(q, 0, longint'(cfg_out_maxval)));
   endfunction

   function automatic colour_result_type convert_pixel(pix_type p);
      colour_result_type res;
      longint r, g, b, den, yv, pbv, prv;
      longint half;
      res = '0;
      if (p.cmd == CMD_FORWARD) begin
         r = longint'(p.red);
         g = longint'(p.green);
         b = longint'(p.blue);
         den = ((cfg_in_maxval == 0) ? longint'(1) : longint'(cfg_in_maxval)) << COEF_BITS;
         half = longint'(1) << (FRAC_BITS - 1);
         yv  = scaled_div_round(K_Y_R * r + K_Y_G * g + K_Y_B * b, den);
         pbv = scaled_div_round(-K_PB_R * r - K_PB_G * g + K_PB_B * b, den);
         prv = scaled_div_round(K_PR_R * r - K_PR_G * g - K_PR_B * b, den);
         res.luma      = SAMPLE_W'(clamp_range(yv, 0, longint'(1) << FRAC_BITS));
         res.blue_diff = SAMPLE_W'(clamp_range(pbv, -half, half));
         res.red_diff  = SAMPLE_W'(clamp_range(prv, -half, half));
      end else begin
         yv  = longint'(p.luma) << COEF_BITS;
         pbv = longint'($signed(p.blue_diff));
         prv = longint'($signed(p.red_diff));
         res.red   = scale_to_rgb(yv + K_R_PR * prv);
         res.green = scale_to_rgb(yv - K_G_PB * pbv - K_G_PR * prv);
         res.blue  = scale_to_rgb(yv + K_B_PB * pbv);
      end
      return res;
   endfunction

   // mostly inside [lo,hi], sometimes an endpoint, sometimes any 16-bit value
   function automatic logic [SAMPLE_W-1:0] draw_value(int lo, int hi);
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         return SAMPLE_W'($urandom);
      else if (pick == 1)
         return SAMPLE_W'($urandom_range(0, 1) ? hi : lo);
      else
         return SAMPLE_W'(int'($urandom_range(0, hi - lo)) + lo);
   endfunction

   function automatic pix_type random_pixel();
      pix_type p;
      int      top;
      top = (cfg_in_maxval == 0) ? 1 : int'(cfg_in_maxval);
      p.cmd       = $urandom_range(0, 1) ? CMD_INVERSE : CMD_FORWARD;
      p.red       = draw_value(0, top);
      p.green     = draw_value(0, top);
      p.blue      = draw_value(0, top);
      p.luma      = draw_value(0, 32768);
      p.blue_diff = draw_value(-16384, 16384);
      p.red_diff  = draw_value(-16384, 16384);
      return p;
   endfunction

   // unused fields carry noise so that the block must ignore them
   function automatic pix_type forward_pixel(int r, int g, int b);
      pix_type p;
      p = random_pixel();
      p.cmd   = CMD_FORWARD;
      p.red   = SAMPLE_W'(r);
      p.green = SAMPLE_W'(g);
      p.blue  = SAMPLE_W'(b);
      return p;
   endfunction

   function automatic pix_type inverse_pixel(int y, int pb, int pr);
      pix_type p;
      p = random_pixel();
      p.cmd       = CMD_INVERSE;
      p.luma      = SAMPLE_W'(y);
      p.blue_diff = SAMPLE_W'(pb);
      p.red_diff  = SAMPLE_W'(pr);
      return p;
   endfunction

   task automatic queue_pixel(pix_type p);
      pending_pixels.push_back(p);
      pixels_queued++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pixels_accepted != pixels_queued || expected_colours.size() != 0);
   endtask

   task automatic write_maxval(logic [CSR_IDX_W-1:0] idx, logic [MAXV_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_IN_MAXVAL)
         cfg_in_maxval = value;
      else
         cfg_out_maxval = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(int in_max, int out_max, int count);
      write_maxval(CSR_IN_MAXVAL, MAXV_W'(in_max));
      write_maxval(CSR_OUT_MAXVAL, MAXV_W'(out_max));
      repeat (count)
         queue_pixel(random_pixel());
      wait_drained();
   endtask

   // driver: bursts of random length separated by random gaps
   always @(negedge clock) begin
      pix_type next_pixel;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            next_pixel = pending_pixels.pop_front();
            req_command   <= next_pixel.cmd;
            req_red       <= next_pixel.red;
            req_green     <= next_pixel.green;
            req_blue      <= next_pixel.blue;
            req_luma      <= next_pixel.luma;
            req_blue_diff <= next_pixel.blue_diff;
            req_red_diff  <= next_pixel.red_diff;
            req_valid     <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure: one of four randomly chosen patterns, drawn anew from time to time
   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase % 40 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_phase % 16) < 10);
      endcase
   end

   // monitor: checks each result transaction, then predicts each accepted one
   always @(posedge clock) begin
      colour_result_type got, want;
      pix_type           seen;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.luma      = rsp_out_luma;
            got.blue_diff = rsp_out_blue_diff;
            got.red_diff  = rsp_out_red_diff;
            got.red       = rsp_out_red;
            got.green     = rsp_out_green;
            got.blue      = rsp_out_blue;
            if (expected_colours.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0d: result with nothing outstanding y=%h pb=%h pr=%h r=%h g=%h b=%h",
                           cycle_count, got.luma, got.blue_diff, got.red_diff,
                           got.red, got.green, got.blue);
            end else begin
               want = expected_colours.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0d: mismatch exp y=%h pb=%h pr=%h r=%h g=%h b=%h",
                               " got y=%h pb=%h pr=%h r=%h g=%h b=%h"}, cycle_count,
                              want.luma, want.blue_diff, want.red_diff,
                              want.red, want.green, want.blue,
                              got.luma, got.blue_diff, got.red_diff,
                              got.red, got.green, got.blue);
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            seen.cmd       = req_command;
            seen.red       = req_red;
            seen.green     = req_green;
            seen.blue      = req_blue;
            seen.luma      = req_luma;
            seen.blue_diff = req_blue_diff;
            seen.red_diff  = req_red_diff;
            expected_colours.push_back(convert_pixel(seen));
            pixels_accepted++;
         end
      end else begin
         req_taken = 1'b0;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners at the reset maxval of 255
      queue_pixel(forward_pixel(0, 0, 0));
      queue_pixel(forward_pixel(255, 255, 255));
      queue_pixel(forward_pixel(255, 0, 0));
      queue_pixel(forward_pixel(0, 255, 0));
      queue_pixel(forward_pixel(0, 0, 255));
      queue_pixel(forward_pixel(65535, 65535, 65535));
      queue_pixel(forward_pixel(65535, 0, 0));
      queue_pixel(forward_pixel(0, 65535, 0));
      queue_pixel(forward_pixel(0, 0, 65535));
      queue_pixel(forward_pixel(65535, 65535, 0));
      queue_pixel(forward_pixel(1, 0, 0));
      queue_pixel(forward_pixel(0, 0, 1));
      queue_pixel(inverse_pixel(0, 0, 0));
      queue_pixel(inverse_pixel(32768, 0, 0));
      queue_pixel(inverse_pixel(0, -16384, -16384));
      queue_pixel(inverse_pixel(32768, 16384, 16384));
      queue_pixel(inverse_pixel(0, 16384, 0));
      queue_pixel(inverse_pixel(32768, -16384, 0));
      queue_pixel(inverse_pixel(16384, 0, 16384));
      queue_pixel(inverse_pixel(16384, 0, -16384));
      queue_pixel(inverse_pixel(65535, 32767, 32767));
      queue_pixel(inverse_pixel(0, -32768, -32768));
      queue_pixel(inverse_pixel(65535, -32768, 32767));
      // hold off until the pipeline has emptied
      wait_drained();

      repeat (100)
         queue_pixel(random_pixel());
      wait_drained();

      run_phase(65535, 65535, 90);
      run_phase(1, 1, 70);
      run_phase(0, 0, 50);
      run_phase(1, 65535, 60);
      run_phase(65535, 1, 60);
      run_phase($urandom_range(2, 65534), $urandom_range(2, 65534), 80);
      run_phase(1023, 4095, 80);

      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
